// File: design/khrf_pkg.sv
// constants and types shared by the keyed hash replay filter
`default_nettype none

package khrf_pkg;

    localparam int DEFAULT_SLOT_COUNT = 1024;

    localparam int WORD_W     = 64;
    localparam int TOKEN_WORDS = 4;
    localparam int TOKEN_W    = WORD_W * TOKEN_WORDS;
    localparam int S_TDATA_W  = TOKEN_W + WORD_W;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int AGE_W      = 63;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT = 2'd2;

    // siphash initialization constants
    localparam logic [WORD_W-1:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] SIP_C3 = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] SIP_FINAL_XOR = 64'h00000000000000ff;
    localparam int                SIP_LEN_SHIFT = 56;
    localparam logic [WORD_W-1:0] SIP_LEN_WORD  = 64'd32 << SIP_LEN_SHIFT;

    // message blocks: four token words then the length block
    localparam int SIP_BLOCKS      = TOKEN_WORDS + 1;
    localparam int SIP_HALF_STEPS  = 2 * (2 * SIP_BLOCKS + 4);
    localparam int STEP_W          = $clog2(SIP_HALF_STEPS);

    // remainder reduction runs a byte of the hash per cycle
    localparam int MOD_BITS_PER_CYC = 8;
    localparam int MOD_CYCLES       = WORD_W / MOD_BITS_PER_CYC;

    typedef logic [3:0][WORD_W-1:0] t_sip_v;
    typedef logic [TOKEN_WORDS-1:0][WORD_W-1:0] t_token;

endpackage

`default_nettype wire

// File: design/keyed_hash_replay_filter.sv
// replay filter top level: siphash sequencer, slot reduction and slot store
`default_nettype none

// The four 64-bit token words of each input word (which also carries a signed
// time) are hashed with SipHash-2-4 under the programmed key, reduced modulo
// SLOT_COUNT to a slot, and checked against that slot of a direct-mapped store;
// the result word carries is_replay in bit 0. One shared half-round unit (two
// 64-bit adds) runs the 14 rounds, then a byte-per-cycle remainder unit reduces
// the hash, then the slot is read into registers, compared and written back,
// and the result is loaded into the output register. The next word is taken
// only once that result has been loaded and the block is idle again.
// A result still waiting in the output register holds the next item in its
// last cycle until that register frees up. After reset the time store is
// swept to zero, one slot a cycle, and no input word is taken until the sweep
// is done; configuration writes are taken at all times and are meant to be
// made while idle.
module keyed_hash_replay_filter #(
    parameter int SLOT_COUNT = khrf_pkg::DEFAULT_SLOT_COUNT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input word
    input  wire logic                             i_s_tvalid,
    output      logic                             o_s_tready,
    // token_word0, token_word1, token_word2, token_word3, now_time
    input  wire logic [khrf_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // result word
    output      logic                             o_m_tvalid,
    input  wire logic                             i_m_tready,
    // is_replay, then zero fill
    output      logic [khrf_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output      logic                             o_cfg_ready,
    input  wire logic [khrf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [khrf_pkg::WORD_W-1:0]      i_cfg_data
);
    import khrf_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W:0]   SLOT_N   = (IDX_W + 1)'(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SIP_HALF_STEPS - 1);
    localparam logic [STEP_W-1:0] LAST_MOD  = STEP_W'(MOD_CYCLES - 1);
    localparam logic [STEP_W-1:0] MSG_STEPS = STEP_W'(4 * SIP_BLOCKS);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HASH  = 7'b0000100,
        S_MOD   = 7'b0001000,
        S_READ  = 7'b0010000,
        S_CHECK = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    function automatic logic [WORD_W-1:0] rotl(logic [WORD_W-1:0] x, int r);
        return (x << r) | (x >> (WORD_W - r));
    endfunction

    // half of a sipround; the second half when sel is set
    function automatic t_sip_v half_round(t_sip_v v, logic sel);
        t_sip_v o;
        o = v;
        if (!sel) begin
            o[0] = v[0] + v[1];
            o[1] = rotl(v[1], 13) ^ o[0];
            o[0] = rotl(o[0], 32);
            o[2] = v[2] + v[3];
            o[3] = rotl(v[3], 16) ^ o[2];
        end else begin
            o[0] = v[0] + v[3];
            o[3] = rotl(v[3], 21) ^ o[0];
            o[2] = v[2] + v[1];
            o[1] = rotl(v[1], 17) ^ o[2];
            o[2] = rotl(o[2], 32);
        end
        return o;
    endfunction

    // control registers
    t_state                r_state, n_state;
    logic [STEP_W-1:0]     r_cnt, n_cnt;
    logic [IDX_W-1:0]      r_clr_idx, n_clr_idx;
    logic                  r_m_valid, n_m_valid;

    // configuration
    logic [WORD_W-1:0]     r_key_low;
    logic [WORD_W-1:0]     r_key_high;
    logic [AGE_W-1:0]      r_age_limit;

    // payload
    t_token                r_tok;
    logic [WORD_W-1:0]     r_now;
    t_sip_v                r_v;
    logic [WORD_W-1:0]     r_hash;
    logic [IDX_W-1:0]      r_rem;
    logic                  r_replay;
    logic                  r_m_bit;

    // slot store
    logic [TOKEN_W-1:0]    r_tok_mem  [SLOT_COUNT];
    logic [WORD_W-1:0]     r_time_mem [SLOT_COUNT];
    logic [TOKEN_W-1:0]    r_rd_tok;
    logic [WORD_W-1:0]     r_rd_time;

    // datapath nets
    logic [2:0]            blk;
    logic                  in_msg;
    logic [WORD_W-1:0]     msg_word;
    t_sip_v                unit_in;
    t_sip_v                unit_out;
    logic [IDX_W-1:0]      rem_next;
    logic [WORD_W-1:0]     age;
    logic                  replay_now;
    logic                  time_we;
    logic [IDX_W-1:0]      time_addr;
    logic [WORD_W-1:0]     time_wdata;
    logic                  accept;
    logic                  out_free;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = {{(M_TDATA_W - 1){1'b0}}, r_m_bit};

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_m_valid || i_m_tready;

    // message word of the current block
    assign blk    = r_cnt[4:2];
    assign in_msg = (r_cnt < MSG_STEPS);
    always_comb begin
        case (blk)
            3'd0:    msg_word = r_tok[0];
            3'd1:    msg_word = r_tok[1];
            3'd2:    msg_word = r_tok[2];
            3'd3:    msg_word = r_tok[3];
            default: msg_word = SIP_LEN_WORD;
        endcase
    end

    // shared half-round unit with the block absorb on either side
    always_comb begin
        unit_in = r_v;
        if (in_msg && (r_cnt[1:0] == 2'd0)) begin
            unit_in[3] = r_v[3] ^ msg_word;
        end
        unit_out = half_round(unit_in, r_cnt[0]);
        if (in_msg && (r_cnt[1:0] == 2'd3)) begin
            unit_out[0] = unit_out[0] ^ msg_word;
            if (blk == 3'(TOKEN_WORDS)) begin
                unit_out[2] = unit_out[2] ^ SIP_FINAL_XOR;
            end
        end
    end

    // remainder step: one hash byte, msb first, folded into the slot index
    always_comb begin
        logic [IDX_W:0] t;
        logic [IDX_W-1:0] r;
        r = r_rem;
        for (int k = 0; k < MOD_BITS_PER_CYC; k++) begin
            t = {r, r_hash[WORD_W-1-k]};
            if (t >= SLOT_N) begin
                t = t - SLOT_N;
            end
            r = t[IDX_W-1:0];
        end
        rem_next = r;
    end

    // slot check
    assign age = r_now - r_rd_time;
    assign replay_now = (r_rd_time != '0) && (r_rd_tok == TOKEN_W'(r_tok)) &&
                        !age[WORD_W-1] && (age[AGE_W-1:0] < r_age_limit);

    // time store write port: clearing sweep or slot update
    always_comb begin
        time_we    = 1'b0;
        time_addr  = r_rem;
        time_wdata = r_now;
        if (r_state == S_CLEAR) begin
            time_we    = 1'b1;
            time_addr  = r_clr_idx;
            time_wdata = '0;
        end else if ((r_state == S_CHECK) && !replay_now) begin
            time_we = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_clr_idx = r_clr_idx;
        n_m_valid = r_m_valid;
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end
        unique case (r_state)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_cnt   = '0;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_MOD) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_clr_idx   <= '0;
            r_m_valid   <= 1'b0;
            r_key_low   <= '0;
            r_key_high  <= '0;
            r_age_limit <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_clr_idx <= n_clr_idx;
            r_m_valid <= n_m_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_KEY_LOW:   r_key_low   <= i_cfg_data;
                    REG_KEY_HIGH:  r_key_high  <= i_cfg_data;
                    REG_AGE_LIMIT: r_age_limit <= i_cfg_data[AGE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tok[0] <= i_s_tdata[0*WORD_W +: WORD_W];
            r_tok[1] <= i_s_tdata[1*WORD_W +: WORD_W];
            r_tok[2] <= i_s_tdata[2*WORD_W +: WORD_W];
            r_tok[3] <= i_s_tdata[3*WORD_W +: WORD_W];
            r_now    <= i_s_tdata[TOKEN_W +: WORD_W];
            r_v[0]   <= SIP_C0 ^ r_key_low;
            r_v[1]   <= SIP_C1 ^ r_key_high;
            r_v[2]   <= SIP_C2 ^ r_key_low;
            r_v[3]   <= SIP_C3 ^ r_key_high;
            r_rem    <= '0;
        end
        if (r_state == S_HASH) begin
            r_v <= unit_out;
            if (r_cnt == LAST_STEP) begin
                r_hash <= unit_out[0] ^ unit_out[1] ^ unit_out[2] ^ unit_out[3];
            end
        end
        if (r_state == S_MOD) begin
            r_rem  <= rem_next;
            r_hash <= r_hash << MOD_BITS_PER_CYC;
        end
        if (r_state == S_CHECK) begin
            r_replay <= replay_now;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_m_bit <= r_replay;
        end
    end

    // token store
    always_ff @(posedge i_clk) begin
        if ((r_state == S_CHECK) && !replay_now) begin
            r_tok_mem[r_rem] <= TOKEN_W'(r_tok);
        end
        r_rd_tok <= r_tok_mem[r_rem];
    end

    // time store
    always_ff @(posedge i_clk) begin
        if (time_we) begin
            r_time_mem[time_addr] <= time_wdata;
        end
        r_rd_time <= r_time_mem[r_rem];
    end

endmodule

`default_nettype wire

// File: test/keyed_hash_replay_filter_checker.sv
// checker for the replay filter: watches all channels, predicts is_replay and compares
`timescale 1ns / 100ps

module keyed_hash_replay_filter_checker #(
    parameter int SLOT_COUNT = khrf_pkg::DEFAULT_SLOT_COUNT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    input  wire logic                           i_s_tready,
    input  wire logic [khrf_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  wire logic                           i_m_tvalid,
    input  wire logic                           i_m_tready,
    input  wire logic [khrf_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_ready,
    input  wire logic [khrf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [khrf_pkg::WORD_W-1:0]    i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    typedef logic [3:0][63:0] t_word4;

    localparam logic [63:0] INIT0 = 64'h736f6d6570736575;
    localparam logic [63:0] INIT1 = 64'h646f72616e646f6d;
    localparam logic [63:0] INIT2 = 64'h6c7967656e657261;
    localparam logic [63:0] INIT3 = 64'h7465646279746573;
    // 32-byte message: length byte in the top byte of the final block
    localparam logic [63:0] LEN_BLOCK = 64'd32 << 56;

    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [62:0] age_limit;

    t_word4      slot_token [SLOT_COUNT];
    logic [63:0] slot_time  [SLOT_COUNT];

    logic [khrf_pkg::M_TDATA_W-1:0] replay_words_q [$];
    int result_count;

    function automatic logic [63:0] rol(logic [63:0] x, int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic t_word4 mix_round(t_word4 v);
        v[0] = v[0] + v[1]; v[1] = rol(v[1], 13); v[1] = v[1] ^ v[0]; v[0] = rol(v[0], 32);
        v[2] = v[2] + v[3]; v[3] = rol(v[3], 16); v[3] = v[3] ^ v[2];
        v[0] = v[0] + v[3]; v[3] = rol(v[3], 21); v[3] = v[3] ^ v[0];
        v[2] = v[2] + v[1]; v[1] = rol(v[1], 17); v[1] = v[1] ^ v[2]; v[2] = rol(v[2], 32);
        return v;
    endfunction

    function automatic logic [63:0] token_hash(t_word4 tok);
        t_word4 v;
        v[0] = INIT0 ^ key_low;
        v[1] = INIT1 ^ key_high;
        v[2] = INIT2 ^ key_low;
        v[3] = INIT3 ^ key_high;
        for (int i = 0; i < 4; i++) begin
            v[3] = v[3] ^ tok[i];
            v = mix_round(mix_round(v));
            v[0] = v[0] ^ tok[i];
        end
        v[3] = v[3] ^ LEN_BLOCK;
        v = mix_round(mix_round(v));
        v[0] = v[0] ^ LEN_BLOCK;
        v[2] = v[2] ^ 64'hff;
        for (int i = 0; i < 4; i++) begin
            v = mix_round(v);
        end
        return v[0] ^ v[1] ^ v[2] ^ v[3];
    endfunction

    // looks the token up in its slot and stores it unless it is a replay
    function automatic logic check_and_store(logic [khrf_pkg::S_TDATA_W-1:0] word);
        t_word4      tok;
        logic [63:0] now_s;
        logic [63:0] age;
        int          slot;
        logic        hit;
        tok   = word[255:0];
        now_s = word[319:256];
        slot  = int'(token_hash(tok) % 64'(SLOT_COUNT));
        hit   = 1'b0;
        if (slot_time[slot] != 64'd0) begin
            if (slot_token[slot] == tok) begin
                age = now_s - slot_time[slot];
                hit = !age[63] && (age < {1'b0, age_limit});
            end
        end
        if (!hit) begin
            slot_token[slot] = tok;
            slot_time[slot]  = now_s;
        end
        return hit;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        result_count = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_low   <= 64'd0;
            key_high  <= 64'd0;
            age_limit <= 63'd0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_time[i] = 64'd0;
            end
            replay_words_q.delete();
            o_pending = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    khrf_pkg::REG_KEY_LOW: begin
                        key_low <= i_cfg_data;
                    end
                    khrf_pkg::REG_KEY_HIGH: begin
                        key_high <= i_cfg_data;
                    end
                    khrf_pkg::REG_AGE_LIMIT: begin
                        age_limit <= i_cfg_data[62:0];
                    end
                    default: begin
                    end
                endcase
            end
            // compare before pushing so a result never meets its own word
            if (i_m_tvalid && i_m_tready) begin
                if (replay_words_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no word waiting, data %h",
                        result_count, i_m_tdata));
                end else begin
                    if (i_m_tdata !== replay_words_q[0]) begin
                        report_mismatch($sformatf("result %0d is_replay word got %h expected %h",
                            result_count, i_m_tdata, replay_words_q[0]));
                    end
                    void'(replay_words_q.pop_front());
                end
                result_count++;
            end
            if (i_s_tvalid && i_s_tready) begin
                replay_words_q.push_back({7'd0, check_and_store(i_s_tdata)});
            end
            o_pending = replay_words_q.size();
        end
    end

endmodule

// File: test/keyed_hash_replay_filter_test.sv
// testbench top for the replay filter: stimulus, idling and verdict
`timescale 1ns / 100ps

module keyed_hash_replay_filter_test;

    localparam int SLOTS = khrf_pkg::DEFAULT_SLOT_COUNT;
    localparam int POOL  = 16;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 172;
    localparam int SETTLE_CYCLES = 64;
    // no register sits at the last index
    localparam logic [khrf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [khrf_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [khrf_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [khrf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [khrf_pkg::WORD_W-1:0]    cfg_data;
    int                             fail_count;
    int                             pending;

    bit          idle_on;
    logic [62:0] age_now;
    logic [63:0] wall;
    logic [255:0] pool_tok   [POOL];
    logic [63:0]  pool_stamp [POOL];
    logic [255:0] tok_a, tok_b, tok_c;
    int          stall_left;

    localparam logic [255:0] TOK_ZERO = '0;
    localparam logic [255:0] TOK_ONES = '1;
    localparam logic [63:0]  T_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0]  T_MIN = 64'h8000_0000_0000_0000;

    keyed_hash_replay_filter #(.SLOT_COUNT(SLOTS)) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    keyed_hash_replay_filter_checker #(.SLOT_COUNT(SLOTS)) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: random stall bursts while idling is on
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 15) == 0) begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(0, 18);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_word(input logic [255:0] tok, input logic [63:0] stamp);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {stamp, tok};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [khrf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == khrf_pkg::REG_AGE_LIMIT) begin
            age_now = value[62:0];
        end
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // mostly repeats of recent tokens so replays and near-misses are common
    task automatic send_random_item();
        int           j;
        int           pick;
        logic [255:0] tok;
        logic [63:0]  stamp;
        j    = $urandom_range(0, POOL - 1);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            tok = pool_tok[j];
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: stamp = pool_stamp[j] + $urandom_range(0, 20);
                5:             stamp = pool_stamp[j];
                6:             stamp = pool_stamp[j] - $urandom_range(1, 20);
                7:             stamp = pool_stamp[j] + {1'b0, age_now} - 64'd1;
                8:             stamp = pool_stamp[j] + {1'b0, age_now};
                default:       stamp = rand64();
            endcase
            pool_stamp[j] = stamp;
        end else if (pick < 90) begin
            tok  = {rand64(), rand64(), rand64(), rand64()};
            wall = wall + $urandom_range(0, 3);
            stamp = wall;
            pool_tok[j]   = tok;
            pool_stamp[j] = stamp;
        end else begin
            tok   = {rand64(), rand64(), rand64(), rand64()};
            stamp = rand64();
            if ($urandom_range(0, 3) == 0) begin
                tok[64 * $urandom_range(0, 3) +: 64] = $urandom_range(0, 1) ? '1 : '0;
            end
        end
        send_word(tok, stamp);
    endtask

    initial begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_on   = 1'b1;
        age_now   = '0;
        wall      = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // zero key, age limit zero: nothing is a replay
        cfg_write(khrf_pkg::REG_KEY_LOW, 64'd0);
        cfg_write(khrf_pkg::REG_KEY_HIGH, 64'd0);
        cfg_write(khrf_pkg::REG_AGE_LIMIT, 64'd0);
        send_word(TOK_ZERO, 64'd1);
        send_word(TOK_ZERO, 64'd2);
        send_word(TOK_ONES, T_MAX);
        wait_drained();

        // window of 100: inside, on the boundary, negative age, zero age, time zero
        tok_a = {rand64(), rand64(), rand64(), rand64()};
        tok_b = {rand64(), rand64(), rand64(), rand64()};
        tok_c = {rand64(), rand64(), rand64(), rand64()};
        cfg_write(khrf_pkg::REG_KEY_LOW, rand64());
        cfg_write(khrf_pkg::REG_KEY_HIGH, rand64());
        cfg_write(khrf_pkg::REG_AGE_LIMIT, 64'd100);
        send_word(tok_a, 64'd50);
        send_word(tok_a, 64'd60);
        send_word(tok_a, 64'd150);
        send_word(tok_a, 64'd249);
        send_word(tok_a, 64'd100);
        send_word(tok_a, 64'd100);
        send_word(tok_b, 64'd0);
        send_word(tok_b, 64'd0);
        send_word(tok_b, 64'd5);
        send_word(tok_b, 64'd6);
        wait_drained();

        // widest window, written with bit 63 set; unused index must be ignored
        cfg_write(khrf_pkg::REG_AGE_LIMIT, 64'hffff_ffff_ffff_ffff);
        cfg_write(REG_UNUSED, rand64());
        cfg_write(khrf_pkg::REG_KEY_LOW, 64'hffff_ffff_ffff_ffff);
        cfg_write(khrf_pkg::REG_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
        send_word(tok_c, T_MIN);
        send_word(tok_c, T_MAX);
        send_word(tok_c, -64'sd5);
        send_word(TOK_ONES, 64'hffff_ffff_ffff_ffff);
        send_word(TOK_ONES, T_MAX - 64'd1);
        send_word(TOK_ZERO, 64'd0);
        send_word(TOK_ZERO, 64'd0);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            cfg_write(khrf_pkg::REG_KEY_LOW, (p == 1) ? 64'hffff_ffff_ffff_ffff : rand64());
            cfg_write(khrf_pkg::REG_KEY_HIGH, (p == 2) ? 64'd0 : rand64());
            case (p)
                0: cfg_write(khrf_pkg::REG_AGE_LIMIT, 64'($urandom_range(1, 30)));
                1: cfg_write(khrf_pkg::REG_AGE_LIMIT, 64'd0);
                2: cfg_write(khrf_pkg::REG_AGE_LIMIT, T_MAX);
                3: cfg_write(khrf_pkg::REG_AGE_LIMIT, rand64() >> $urandom_range(1, 63));
                4: cfg_write(khrf_pkg::REG_AGE_LIMIT, 64'd1);
                default: cfg_write(khrf_pkg::REG_AGE_LIMIT, 64'($urandom_range(5, 200)));
            endcase
            if (p == PHASES - 1) begin
                cfg_write(REG_UNUSED, rand64());
            end
            idle_on = (p != PHASES - 1);
            wall = (p == 3) ? T_MAX - 64'd300 : rand64();
            for (int j = 0; j < POOL; j++) begin
                pool_tok[j]   = {rand64(), rand64(), rand64(), rand64()};
                pool_stamp[j] = wall;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold the sender until the block has answered everything
                if (p == 2 && n == 80) begin
                    s_tvalid = 1'b0;
                    while (pending != 0) @(negedge clk);
                end
                send_random_item();
            end
            wait_drained();
        end

        repeat (100) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
